@@ rtl/core/drl_pkg.sv @@
// Shared types and constants of the dual request rate limiter.
// Used by every module of the block but the checker; depends on nothing else.
package drl_pkg;

  localparam int unsigned LogDepth = 4096;
  localparam int unsigned LogAw    = $clog2(LogDepth);

  localparam logic [1:0] CFG_RATE   = 2'd0;
  localparam logic [1:0] CFG_CAP    = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;
  localparam logic [1:0] CFG_MAX    = 2'd3;

  localparam logic [39:0] RATE_RST   = 40'd4294967296;
  localparam logic [15:0] CAP_RST    = 16'd16;
  localparam logic [31:0] WINDOW_RST = 32'd1000000;
  localparam logic [12:0] MAX_RST    = 13'd64;

  localparam logic [47:0] ONE_TOKEN = 48'h0001_0000_0000;

  typedef struct packed {
    logic        done;
    logic        pass;
    logic [15:0] whole;
  } bkt_res_t;

  typedef struct packed {
    logic        done;
    logic        pass;
    logic [12:0] free;
  } win_res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/core/dual_request_rate_limiter_unit.sv @@
// Dual request rate limiter: token bucket plus sliding-window stamp log.
// Input channel in_valid_i/in_ready_o carries kind_i (0 request, 1 restart)
// and stamp_i, a nondecreasing tick count. Each transaction yields exactly one
// result transaction on out_valid_o/out_ready_i with the grant flags, the
// whole tokens left, the free window slots and four saturating counters.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i and are always taken; write them only while the block is idle.
// A request's result is loaded once the bucket and the window have both
// finished; the window takes longer when expired log entries are popped, since
// popping reads the stamp log RAM one entry per cycle. The bucket refill forms
// its two partial products in turn. A restart goes straight to the output
// state, and its result is loaded as soon as the output register is free. The
// input is ready again the cycle after a result is loaded.
// A result is loaded as soon as the output register is free, even when the
// receiver stalls it; the next input is then taken, and its result waits until
// the register drains. Reset fills the bucket to 16 tokens, empties the log and
// clears the counters; the log memory itself needs no clearing.
// Depends on drl_pkg, drl_bucket, drl_window and drl_log_ram.
module dual_request_rate_limiter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        allowed_o,
  output logic        burst_refused_o,
  output logic        window_refused_o,
  output logic [15:0] tokens_whole_o,
  output logic [12:0] window_free_o,
  output logic [31:0] bucket_passes_o,
  output logic [31:0] bucket_refusals_o,
  output logic [31:0] window_passes_o,
  output logic [31:0] window_refusals_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i
);
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_WAIT = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [1:0]  state_q;
  logic [39:0] rate_q;
  logic [15:0] cap_q;
  logic [31:0] window_q;
  logic [12:0] max_q;
  logic        req_q;
  logic [31:0] bp_q, br_q, wp_q, wr_q;
  logic        out_valid_q;
  logic        accept, start, restart, load;
  drl_pkg::bkt_res_t bkt;
  drl_pkg::win_res_t win;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == T_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign start       = accept && !kind_i;
  assign restart     = accept && kind_i;
  assign load        = (state_q == T_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= drl_pkg::RATE_RST;
      cap_q    <= drl_pkg::CAP_RST;
      window_q <= drl_pkg::WINDOW_RST;
      max_q    <= drl_pkg::MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        drl_pkg::CFG_RATE:   rate_q   <= cfg_data_i;
        drl_pkg::CFG_CAP:    cap_q    <= cfg_data_i[15:0];
        drl_pkg::CFG_WINDOW: window_q <= cfg_data_i[31:0];
        drl_pkg::CFG_MAX:    max_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      req_q       <= 1'b0;
      bp_q        <= '0;
      br_q        <= '0;
      wp_q        <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (restart) begin
            req_q   <= 1'b0;
            bp_q    <= '0;
            br_q    <= '0;
            wp_q    <= '0;
            wr_q    <= '0;
            state_q <= T_OUT;
          end else if (start) begin
            req_q   <= 1'b1;
            state_q <= T_WAIT;
          end
        end
        T_WAIT: begin
          // Both units clear their done flag on start and raise it when finished.
          if (bkt.done && win.done) begin
            if (bkt.pass) bp_q <= drl_pkg::sat_inc(bp_q);
            else          br_q <= drl_pkg::sat_inc(br_q);
            if (win.pass) wp_q <= drl_pkg::sat_inc(wp_q);
            else          wr_q <= drl_pkg::sat_inc(wr_q);
            state_q <= T_OUT;
          end
        end
        T_OUT: begin
          if (load) begin
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      allowed_o         <= req_q && bkt.pass && win.pass;
      burst_refused_o   <= req_q && !bkt.pass;
      window_refused_o  <= req_q && !win.pass;
      tokens_whole_o    <= bkt.whole;
      window_free_o     <= win.free;
      bucket_passes_o   <= bp_q;
      bucket_refusals_o <= br_q;
      window_passes_o   <= wp_q;
      window_refusals_o <= wr_q;
    end
  end

  assign out_valid_o = out_valid_q;

  drl_bucket u_bucket (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .restart_i (restart),
    .stamp_i   (stamp_i),
    .rate_i    (rate_q),
    .cap_i     (cap_q),
    .res_o     (bkt)
  );

  drl_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .restart_i (restart),
    .stamp_i   (stamp_i),
    .window_i  (window_q),
    .max_i     (max_q),
    .res_o     (win)
  );
endmodule

@@ rtl/core/drl_log_ram.sv @@
// Stamp log storage: one write port and one read port, registered read data.
// Sized from drl_pkg.
module drl_log_ram (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [drl_pkg::LogAw-1:0] wr_addr_i,
  input  logic [31:0]               wr_data_i,
  input  logic                      rd_en_i,
  input  logic [drl_pkg::LogAw-1:0] rd_addr_i,
  output logic [31:0]               rd_data_o
);
  logic [31:0] mem [drl_pkg::LogDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

@@ rtl/core/drl_bucket.sv @@
// Token bucket: refill by elapsed ticks times rate, cap, take one token.
// Uses drl_pkg; the 32x40 product is built from two 32x20 partial products.
module drl_bucket (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              restart_i,
  input  logic [31:0]       stamp_i,
  input  logic [39:0]       rate_i,
  input  logic [15:0]       cap_i,
  output drl_pkg::bkt_res_t res_o
);
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MLO  = 3'd1;
  localparam logic [2:0] B_MHI  = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_TAKE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [47:0] level_q, level_d;
  logic [31:0] refill_q, refill_d;
  logic [31:0] now_q, elapsed_q;
  logic [51:0] pp0_q, pp1_q;
  logic        done_q, done_d, pass_q, pass_d;
  logic [71:0] prod;
  logic [49:0] sum;
  logic [47:0] cap48;
  logic        over;

  assign cap48 = {cap_i, 32'd0};
  assign prod  = {20'd0, pp0_q} + {pp1_q, 20'd0};
  assign sum   = {2'd0, level_q} + {1'b0, prod[48:0]};
  assign over  = (|prod[71:49]) || (sum > {2'd0, cap48});

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    refill_d = refill_q;
    done_d   = done_q;
    pass_d   = pass_q;
    case (state_q)
      B_IDLE: begin
        if (restart_i) begin
          level_d  = cap48;
          refill_d = stamp_i;
        end else if (start_i) begin
          done_d  = 1'b0;
          state_d = B_MLO;
        end
      end
      B_MLO: state_d = B_MHI;
      B_MHI: state_d = B_SUM;
      B_SUM: begin
        if (elapsed_q != 32'd0) begin
          level_d  = over ? cap48 : sum[47:0];
          refill_d = now_q;
        end
        state_d = B_TAKE;
      end
      B_TAKE: begin
        pass_d = level_q >= drl_pkg::ONE_TOKEN;
        if (level_q >= drl_pkg::ONE_TOKEN) begin
          level_d = level_q - drl_pkg::ONE_TOKEN;
        end
        done_d  = 1'b1;
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      level_q  <= {drl_pkg::CAP_RST, 32'd0};
      refill_q <= 32'd0;
      done_q   <= 1'b0;
      pass_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      refill_q <= refill_d;
      done_q   <= done_d;
      pass_q   <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && start_i) begin
      now_q     <= stamp_i;
      elapsed_q <= stamp_i - refill_q;
    end
    if (state_q == B_MLO) begin
      pp0_q <= 52'(elapsed_q) * 52'(rate_i[19:0]);
    end
    if (state_q == B_MHI) begin
      pp1_q <= 52'(elapsed_q) * 52'(rate_i[39:20]);
    end
  end

  assign res_o.done  = done_q;
  assign res_o.pass  = pass_q;
  assign res_o.whole = level_q[47:32];
endmodule

@@ rtl/core/drl_window.sv @@
// Sliding-window log: pops expired stamps one per cycle, then logs a request that fits.
// Uses drl_pkg and drl_log_ram.
module drl_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              restart_i,
  input  logic [31:0]       stamp_i,
  input  logic [31:0]       window_i,
  input  logic [12:0]       max_i,
  output drl_pkg::win_res_t res_o
);
  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_CHK  = 2'd1;
  localparam logic [1:0] W_DEC  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [drl_pkg::LogAw-1:0] oldest_q, oldest_d;
  logic [drl_pkg::LogAw:0]   fill_q, fill_d;
  logic                      done_q, done_d, pass_q, pass_d;
  logic [31:0]               now_q, rd_data, age;
  logic                      rd_en, wr_en;
  logic [drl_pkg::LogAw-1:0] rd_addr, wr_addr;

  assign age     = now_q - rd_data;
  assign wr_addr = oldest_q + fill_q[drl_pkg::LogAw-1:0];

  always_comb begin
    state_d  = state_q;
    oldest_d = oldest_q;
    fill_d   = fill_q;
    done_d   = done_q;
    pass_d   = pass_q;
    rd_en    = 1'b0;
    rd_addr  = oldest_q;
    wr_en    = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (restart_i) begin
          oldest_d = '0;
          fill_d   = '0;
        end else if (start_i) begin
          done_d = 1'b0;
          if (fill_q != '0) begin
            rd_en   = 1'b1;
            state_d = W_CHK;
          end else begin
            state_d = W_DEC;
          end
        end
      end
      W_CHK: begin
        if (age >= window_i) begin
          oldest_d = oldest_q + 1'b1;
          fill_d   = fill_q - 1'b1;
          rd_addr  = oldest_q + 1'b1;
          if (fill_d != '0) begin
            rd_en = 1'b1;
          end else begin
            state_d = W_DEC;
          end
        end else begin
          state_d = W_DEC;
        end
      end
      W_DEC: begin
        if ({3'd0, fill_q} < {3'd0, max_i} &&
            fill_q != (drl_pkg::LogAw + 1)'(drl_pkg::LogDepth)) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 1'b1;
          pass_d = 1'b1;
        end else begin
          pass_d = 1'b0;
        end
        done_d  = 1'b1;
        state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      oldest_q <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      pass_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
      done_q   <= done_d;
      pass_q   <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      now_q <= stamp_i;
    end
  end

  drl_log_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (now_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign res_o.done = done_q;
  assign res_o.pass = pass_q;
  assign res_o.free = (max_i > 13'(fill_q)) ? max_i - 13'(fill_q) : 13'd0;
endmodule

@@ rtl/core/drl_checker.sv @@
// Port-level checks of the rate limiter over time, attached by bind.
// Sees only the top-level ports of dual_request_rate_limiter_unit.
module drl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        allowed_o,
  input logic        burst_refused_o,
  input logic        window_refused_o,
  input logic [31:0] bucket_passes_o
);
  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A granted request never carries a refusal flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allowed_o |-> !burst_refused_o && !window_refused_o)
    else $error("grant with refusal");

  // One transaction at a time: the cycle after an accept takes no input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // A grant means the bucket handed out a token, so its count is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allowed_o |-> bucket_passes_o != 32'd0)
    else $error("grant without bucket pass count");
endmodule

bind dual_request_rate_limiter_unit drl_checker u_drl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .allowed_o        (allowed_o),
  .burst_refused_o  (burst_refused_o),
  .window_refused_o (window_refused_o),
  .bucket_passes_o  (bucket_passes_o)
);

@@ verif/dual_request_rate_limiter_unit_test.sv @@
// Testbench of the dual request rate limiter: a directed table, then random
// request streams under several register settings, checked against a predictor.
// Depends on drl_pkg and dual_request_rate_limiter_unit.
`timescale 1ns / 100ps

module dual_request_rate_limiter_unit_test;

  localparam bit KIND_REQ     = 1'b0;
  localparam bit KIND_RESTART = 1'b1;

  typedef struct packed {
    logic        allowed;
    logic        burst_refused;
    logic        window_refused;
    logic [15:0] tokens_whole;
    logic [12:0] window_free;
    logic [31:0] bucket_passes;
    logic [31:0] bucket_refusals;
    logic [31:0] window_passes;
    logic [31:0] window_refusals;
  } verdict_t;

  typedef struct {
    bit          kind;
    logic [31:0] stamp;
    int          reps;
    bit          typed;
    verdict_t    verdict;
  } table_row_t;

  typedef struct {
    logic [39:0] rate;
    logic [15:0] cap;
    logic [31:0] window;
    logic [12:0] limit;
    int unsigned scale;
    int          items;
  } setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [31:0] stamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        allowed_o, burst_refused_o, window_refused_o;
  logic [15:0] tokens_whole_o;
  logic [12:0] window_free_o;
  logic [31:0] bucket_passes_o, bucket_refusals_o, window_passes_o, window_refusals_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = drl_pkg::CFG_RATE;
  logic [39:0] cfg_data_i = '0;

  dual_request_rate_limiter_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("dual_request_rate_limiter_unit: mismatch");
    $finish;
  end

  // Predictor state and its copy of the registers.
  longint unsigned rate_q, level_q;
  logic [15:0] cap_q;
  logic [31:0] window_q;
  logic [12:0] limit_q;
  logic [31:0] refill_at_q;
  logic [31:0] stamp_log_q [drl_pkg::LogDepth];
  int unsigned oldest_q, fill_q;
  logic [31:0] bkt_pass_q, bkt_refuse_q, win_pass_q, win_refuse_q;

  verdict_t    pending_q[$];
  int          errors = 0;
  int          rx_stall = 0;
  int          rx_hold = 0;
  bit          no_idle = 1'b0;
  logic [31:0] now_stamp = '0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void restart_limiter(input logic [31:0] s);
    level_q = longint'(cap_q) << 32;
    refill_at_q = s;
    oldest_q = 0;
    fill_q = 0;
    bkt_pass_q = '0;
    bkt_refuse_q = '0;
    win_pass_q = '0;
    win_refuse_q = '0;
  endfunction

  function automatic verdict_t predict_verdict(input bit k, input logic [31:0] s);
    verdict_t v;
    logic [31:0] elapsed, age;
    longint unsigned cap_fx, add;
    bit bkt_ok, win_ok;
    int unsigned slot;
    v = '0;
    if (k == KIND_RESTART) begin
      restart_limiter(s);
    end else begin
      elapsed = s - refill_at_q;
      cap_fx = longint'(cap_q) << 32;
      if (elapsed != 0) begin
        if (rate_q != 0 && longint'(elapsed) > cap_fx / rate_q) add = cap_fx;
        else add = longint'(elapsed) * rate_q;
        level_q += add;
        if (level_q > cap_fx) level_q = cap_fx;
        refill_at_q = s;
      end
      bkt_ok = level_q >= 64'h1_0000_0000;
      if (bkt_ok) begin
        level_q -= 64'h1_0000_0000;
        bkt_pass_q = bump(bkt_pass_q);
      end else begin
        bkt_refuse_q = bump(bkt_refuse_q);
      end
      // Expired stamps leave from the oldest end until a younger one is found.
      while (fill_q > 0) begin
        age = s - stamp_log_q[oldest_q];
        if (age < window_q) break;
        oldest_q = (oldest_q + 1 >= drl_pkg::LogDepth) ? 0 : oldest_q + 1;
        fill_q--;
      end
      win_ok = fill_q < limit_q && fill_q < drl_pkg::LogDepth;
      if (win_ok) begin
        slot = (oldest_q + fill_q) % drl_pkg::LogDepth;
        stamp_log_q[slot] = s;
        fill_q++;
        win_pass_q = bump(win_pass_q);
      end else begin
        win_refuse_q = bump(win_refuse_q);
      end
      v.allowed = bkt_ok && win_ok;
      v.burst_refused = !bkt_ok;
      v.window_refused = !win_ok;
    end
    v.tokens_whole = level_q[47:32];
    v.window_free = (limit_q > fill_q) ? 13'(limit_q - fill_q) : 13'd0;
    v.bucket_passes = bkt_pass_q;
    v.bucket_refusals = bkt_refuse_q;
    v.window_passes = win_pass_q;
    v.window_refusals = win_refuse_q;
    return v;
  endfunction

  // Result monitor; the receiver draws a fresh stall after every transaction.
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{allowed_o, burst_refused_o, window_refused_o, tokens_whole_o, window_free_o,
              bucket_passes_o, bucket_refusals_o, window_passes_o, window_refusals_o};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("result differs: expected %h, got %h", want, got);
        end
      end
      rx_stall = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input bit k, input logic [31:0] s, input bit typed,
                           input verdict_t typed_v);
    int gap;
    verdict_t v;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    stamp_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    v = predict_verdict(k, s);
    if (typed && v !== typed_v) begin
      errors++;
      if (errors <= 10) $display("table row disagrees: typed %h, predicted %h", typed_v, v);
    end
    pending_q.push_back(v);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [39:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      drl_pkg::CFG_RATE:   rate_q = data;
      drl_pkg::CFG_CAP:    cap_q = data[15:0];
      drl_pkg::CFG_WINDOW: window_q = data[31:0];
      drl_pkg::CFG_MAX:    limit_q = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input setting_t c);
    write_reg(drl_pkg::CFG_RATE, c.rate);
    write_reg(drl_pkg::CFG_CAP, 40'(c.cap));
    write_reg(drl_pkg::CFG_WINDOW, 40'(c.window));
    write_reg(drl_pkg::CFG_MAX, 40'(c.limit));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] next_stamp(input int unsigned scale);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return now_stamp;
    if (pick < 80) return now_stamp + $urandom_range(0, scale);
    if (pick < 95) return now_stamp + $urandom_range(0, 4 * scale);
    return now_stamp + $urandom;
  endfunction

  table_row_t dir_rows[] = '{
    '{KIND_REQ, 32'd0, 1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'd15, 13'd63, 32'd1, 32'd0, 32'd1, 32'd0}},
    '{KIND_REQ, 32'd0, 1, 1'b0, '0},
    '{KIND_RESTART, 32'hFFFF_FFFF, 1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 16'd16, 13'd64, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{KIND_REQ, 32'd0, 1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'd15, 13'd63, 32'd1, 32'd0, 32'd1, 32'd0}},
    '{KIND_REQ, 32'd0, 17, 1'b0, '0},
    '{KIND_REQ, 32'd5, 2, 1'b0, '0},
    '{KIND_REQ, 32'd1000000, 1, 1'b0, '0},
    '{KIND_REQ, 32'd1000001, 1, 1'b0, '0},
    '{KIND_RESTART, 32'h8000_0000, 1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 16'd16, 13'd64, 32'd0, 32'd0, 32'd0, 32'd0}}
  };

  setting_t plan[] = '{
    '{40'h1_0000_0000, 16'd4, 32'd50, 13'd8, 20, 80},
    '{40'd1, 16'd1, 32'd1, 13'd1, 3, 50},
    '{40'hFF_FFFF_FFFF, 16'd65535, 32'hFFFF_FFFF, 13'd4096, 1000, 60},
    '{40'h0_4000_0000, 16'd2, 32'd30, 13'd5, 10, 70},
    '{40'd0, 16'd0, 32'd0, 13'd0, 5, 30},
    '{40'h3_0000_0000, 16'd9, 32'd200, 13'd8191, 60, 60},
    '{40'h0_0100_0000, 16'd12, 32'd1000, 13'd16, 300, 80},
    '{40'h2_8000_0000, 16'd7, 32'd40, 13'd3, 15, 60}
  };

  initial begin
    setting_t fill_set;
    rate_q = drl_pkg::RATE_RST;
    cap_q = drl_pkg::CAP_RST;
    window_q = drl_pkg::WINDOW_RST;
    limit_q = drl_pkg::MAX_RST;
    restart_limiter(32'd0);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].kind, dir_rows[r].stamp, dir_rows[r].typed, dir_rows[r].verdict);
    end
    now_stamp = 32'h8000_0000;
    drain_results();

    foreach (plan[p]) begin
      apply_setting(plan[p]);
      no_idle = (p % 3 == 2);
      for (int i = 0; i < plan[p].items; i++) begin
        if (p == 3 && i == 10) rx_hold = 300;
        if ($urandom_range(0, 99) < 4) begin
          now_stamp = next_stamp(plan[p].scale);
          send_item(KIND_RESTART, now_stamp, 1'b0, '0);
        end else begin
          now_stamp = next_stamp(plan[p].scale);
          send_item(KIND_REQ, now_stamp, 1'b0, '0);
        end
        // The sender waits once for every outstanding result mid-phase.
        if (p == 6 && i == 40) drain_results();
      end
      drain_results();
    end

    // Log a run of requests with a limit above the depth, then expire them all.
    fill_set = '{40'h1_0000_0000, 16'd3, 32'hFFFF_FFFF, 13'd8191, 0, 0};
    apply_setting(fill_set);
    no_idle = 1'b1;
    repeat (30) send_item(KIND_REQ, now_stamp, 1'b0, '0);
    drain_results();
    write_reg(drl_pkg::CFG_WINDOW, 40'd1);
    cfg_valid_i <= 1'b0;
    no_idle = 1'b0;
    now_stamp = now_stamp + 32'd1;
    repeat (3) send_item(KIND_REQ, now_stamp, 1'b0, '0);
    drain_results();

    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("dual_request_rate_limiter_unit: match");
    end else begin
      $display("dual_request_rate_limiter_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ dual_request_rate_limiter_unit.f @@
rtl/core/drl_pkg.sv
rtl/core/drl_log_ram.sv
rtl/core/drl_bucket.sv
rtl/core/drl_window.sv
rtl/core/dual_request_rate_limiter_unit.sv
rtl/core/drl_checker.sv
verif/dual_request_rate_limiter_unit_test.sv
